/* design/hbw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbw_pkg: shared types and constants of the heartbeat watchdog
// Item layouts, configuration and state records, operation and register codes.
// ----------------------------------------------------------------------------
package hbw_pkg;

    localparam int TIME_BITS = 48;
    localparam int REG_BITS  = 32;
    localparam int ADDR_BITS = 3;
    // compare width wide enough for both an age and a limit
    localparam int CMP_BITS  = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;

    localparam logic [REG_BITS-1:0] STALE_TIMEOUT_RESET = 32'd100000;
    localparam logic [REG_BITS-1:0] GRACE_WINDOW_RESET  = 32'd2000000;

    typedef enum logic {
        OP_FEED  = 1'b0,
        OP_CHECK = 1'b1
    } hbw_op_t;

    typedef enum logic {
        REG_STALE_TIMEOUT = 1'b0,
        REG_GRACE_WINDOW  = 1'b1
    } hbw_reg_idx_t;

    typedef struct packed {
        hbw_op_t              op;
        logic [TIME_BITS-1:0] stamp;
    } hbw_in_t;

    typedef struct packed {
        logic healthy;
        logic halt_now;
        logic halted;
    } hbw_out_t;

    typedef struct packed {
        logic [REG_BITS-1:0] stale_timeout;
        logic [REG_BITS-1:0] grace_window;
    } hbw_cfg_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] last_beat;
        logic                 beat_seen;
        logic [TIME_BITS-1:0] first_check_time;
        logic                 check_seen;
        logic                 tripped;
    } hbw_state_t;

endpackage

/* design/hbw_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbw_regs: configuration register file
// Holds stale timeout and grace window, written and read over the APB port.
// ----------------------------------------------------------------------------
module hbw_regs
    import hbw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [REG_BITS-1:0]  pwdata,
    output logic [REG_BITS-1:0]  prdata,
    output hbw_cfg_t             cfg
);

    hbw_cfg_t     cfg_reg;
    hbw_reg_idx_t idx;
    logic         wr_en;

    assign idx   = hbw_reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stale_timeout <= STALE_TIMEOUT_RESET;
            cfg_reg.grace_window  <= GRACE_WINDOW_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_STALE_TIMEOUT: cfg_reg.stale_timeout <= pwdata;
                REG_GRACE_WINDOW:  cfg_reg.grace_window  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_STALE_TIMEOUT: prdata = cfg_reg.stale_timeout;
            REG_GRACE_WINDOW:  prdata = cfg_reg.grace_window;
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* design/hbw_judge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbw_judge: per-item evaluation
// Decides feed acceptance and trip for one item against the watchdog state.
// ----------------------------------------------------------------------------
module hbw_judge
    import hbw_pkg::*;
(
    input  hbw_in_t    item,
    input  hbw_state_t state,
    input  hbw_cfg_t   cfg,
    output hbw_out_t   result,
    output hbw_state_t state_next
);

    logic [TIME_BITS-1:0] earlier;
    logic [REG_BITS-1:0]  limit;
    logic [TIME_BITS:0]   diff;
    logic                 trip;

    // reference point: last heartbeat, else start of grace (this check if first)
    always_comb begin
        if (state.beat_seen) begin
            earlier = state.last_beat;
            limit   = cfg.stale_timeout;
        end else begin
            earlier = state.check_seen ? state.first_check_time : item.stamp;
            limit   = cfg.grace_window;
        end
    end

    // borrow out means negative age, which never trips
    assign diff = {1'b0, item.stamp} - {1'b0, earlier};
    assign trip = !diff[TIME_BITS]
               && (CMP_BITS'(diff[TIME_BITS-1:0]) > CMP_BITS'(limit));

    always_comb begin
        state_next = state;
        result     = '0;
        case (item.op)
            OP_FEED: begin
                if (!state.beat_seen || (item.stamp > state.last_beat)) begin
                    state_next.last_beat = item.stamp;
                    state_next.beat_seen = 1'b1;
                end
            end
            OP_CHECK: begin
                if (state.tripped) begin
                    result.halted = 1'b1;
                end else begin
                    if (!state.check_seen) begin
                        state_next.first_check_time = item.stamp;
                        state_next.check_seen       = 1'b1;
                    end
                    state_next.tripped = trip;
                    result.healthy     = !trip;
                    result.halt_now    = trip;
                    result.halted      = trip;
                end
            end
            default: ;
        endcase
    end

endmodule

/* design/heartbeat_watchdog_with_grace.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_watchdog_with_grace: timestamped heartbeat watchdog, top level
// Input register, single-pass evaluation, output register, APB config.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries items: op feed stores a heartbeat time if it is newer
//   than the last one, op check compares the current time against the last
//   heartbeat (or the startup grace window before any heartbeat).
//   m_ channel returns one result per check item and nothing for a feed:
//   healthy, halt_now (pulses only on the tripping check) and halted.
//   The APB port holds stale_timeout at 0x0 and grace_window at 0x4; write
//   them only while no item is in flight.
// Timing:
//   Items are registered in the input register, a check's result in the output
//   register. One item is taken every cycle unless a check waits on a stalled
//   output; the path is one 48-bit subtract and compare.
// Reset:
//   aresetn (synchronous, low) empties both stages, clears the heartbeat,
//   first-check and trip state and reloads the register defaults.
// Stall:
//   While m_ready is low the result holds; a check waiting in the input
//   register then holds too, while a feed still passes through.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_with_grace
    import hbw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // item input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hbw_in_t              s_item,
    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output hbw_out_t             m_item,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [REG_BITS-1:0]  pwdata,
    output logic [REG_BITS-1:0]  prdata,
    output logic                 pready
);

    hbw_cfg_t   cfg;
    hbw_state_t state_reg;
    hbw_state_t state_next;
    hbw_in_t    in_item_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    hbw_out_t   out_item_reg;
    hbw_out_t   result;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       advance;
    logic       is_check;

    assign pready = 1'b1;

    hbw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    hbw_judge u_judge (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .result     (result),
        .state_next (state_next)
    );

    // A feed never needs the output slot; a check needs it free or draining.
    assign is_check = (in_item_reg.op == OP_CHECK);
    assign advance  = in_valid_reg && (!is_check || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && is_check) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && is_check) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

/* design/hbw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbw_checker: port-level checks of the heartbeat watchdog
// Watches the result channel for trip latching and result consistency.
// ----------------------------------------------------------------------------
module hbw_checker
    import hbw_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input hbw_out_t m_item
);

    logic seen_halt_reg;
    logic seen_halt_next;

    assign seen_halt_next = seen_halt_reg || (m_valid && m_ready && m_item.halted);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_halt_reg <= 1'b0;
        end else begin
            seen_halt_reg <= seen_halt_next;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // healthy and halted are complementary on every result
    a_halted_vs_healthy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.halted != m_item.healthy))
        else $error("healthy and halted disagree");

    // a trip pulse always comes with the latch set
    a_pulse_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.halt_now |-> m_item.halted)
        else $error("halt pulse without latched halt");

    // once halted has been delivered, it stays and never pulses again
    a_latch_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_halt_reg |-> m_item.halted && !m_item.halt_now)
        else $error("trip latch released or pulsed twice");

endmodule

bind heartbeat_watchdog_with_grace hbw_checker u_hbw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

/* bench/heartbeat_watchdog_with_grace_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_watchdog_with_grace_tb: self-checking bench for the watchdog
// Drives feed and check items through the valid/ready input channel, programs
// the timeout registers over APB between phases, and compares every status
// item against an in-bench watchdog predictor. Traffic runs under three
// idling mixes plus a long output stall, and trips the latch only at the end.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_with_grace_tb;
    import hbw_pkg::*;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    hbw_in_t              s_item;
    logic                 m_valid;
    logic                 m_ready;
    hbw_out_t             m_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [REG_BITS-1:0]  pwdata;
    logic [REG_BITS-1:0]  prdata;
    logic                 pready;

    heartbeat_watchdog_with_grace u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Watchdog predictor: register copies and tracked state
    // ------------------------------------------------------------------------
    logic [REG_BITS-1:0]  stale_limit = STALE_TIMEOUT_RESET;
    logic [REG_BITS-1:0]  grace_limit = GRACE_WINDOW_RESET;
    logic [TIME_BITS-1:0] beat_time   = '0;
    logic                 beat_known  = 1'b0;
    logic [TIME_BITS-1:0] start_time  = '0;
    logic                 start_known = 1'b0;
    logic                 trip_latch  = 1'b0;

    // status items predicted but not yet seen on the output
    hbw_out_t status_due[$];

    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    // ------------------------------------------------------------------------
    // Clock, and a run limit far beyond the slowest legal run
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Mismatch reporting: print one line per mismatch and count it
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch: %s got %0h expected %0h at %0t ns", what, got, want, $time);
        mismatches++;
    endtask

    // True when later is strictly after earlier by more than limit ticks;
    // a negative age never counts.
    function automatic bit age_past_limit(input logic [TIME_BITS-1:0] later,
                                          input logic [TIME_BITS-1:0] earlier,
                                          input logic [REG_BITS-1:0]  limit);
        return (later > earlier) && (CMP_BITS'(later - earlier) > CMP_BITS'(limit));
    endfunction

    // Advance the predictor by one accepted item and queue the status item
    // that a check produces.
    task automatic predict_watchdog(input hbw_in_t it);
        hbw_out_t status;
        bit       trips;
        if (it.op == OP_FEED) begin
            // first feed always lands, later ones only when strictly newer
            if (!beat_known || it.stamp > beat_time) begin
                beat_time  = it.stamp;
                beat_known = 1'b1;
            end
        end else if (trip_latch) begin
            // latched: report halted, touch nothing
            status.healthy  = 1'b0;
            status.halt_now = 1'b0;
            status.halted   = 1'b1;
            status_due.push_back(status);
        end else begin
            if (!start_known) begin
                start_time  = it.stamp;
                start_known = 1'b1;
            end
            if (!beat_known) trips = age_past_limit(it.stamp, start_time, grace_limit);
            else             trips = age_past_limit(it.stamp, beat_time, stale_limit);
            if (trips) trip_latch = 1'b1;
            status.healthy  = !trips;
            status.halt_now = trips;
            status.halted   = trip_latch;
            status_due.push_back(status);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: offer one item, idling first at the current rate, and hold it
    // until it is accepted. Prediction runs at the accepting edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input hbw_op_t op, input logic [TIME_BITS-1:0] stamp);
        hbw_in_t it;
        it.op    = op;
        it.stamp = stamp;
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_watchdog(it);
    endtask

    // Drop valid, wait for every status item, then let a trailing feed
    // leave the pipeline before the registers are touched.
    task automatic drain_items();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // APB: write one register, read it back, update the predictor's copy
    // ------------------------------------------------------------------------
    task automatic cfg_write(input hbw_reg_idx_t idx, input logic [REG_BITS-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(32'(idx) << 2);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_STALE_TIMEOUT) stale_limit = value;
        else                          grace_limit = value;
        // read setup
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== value) report_mismatch("register readback", prdata, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall at the current rate, or hold off completely while a
    // long stall is counting down.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every accepted status item against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_status
        hbw_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_due.size() == 0) begin
                report_mismatch("status item with none expected", m_item, 0);
            end else begin
                want = status_due.pop_front();
                if (m_item.healthy !== want.healthy)
                    report_mismatch("healthy", m_item.healthy, want.healthy);
                if (m_item.halt_now !== want.halt_now)
                    report_mismatch("halt_now", m_item.halt_now, want.halt_now);
                if (m_item.halted !== want.halted)
                    report_mismatch("halted", m_item.halted, want.halted);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Random traffic that never trips: mostly well-formed heartbeats and
    // checks within the limit, plus stale feeds and checks behind the reference point.
    // ------------------------------------------------------------------------
    task automatic run_traffic(input int count);
        logic [TIME_BITS-1:0] base;
        logic [TIME_BITS-1:0] noise;
        logic [TIME_BITS-1:0] back;
        logic [REG_BITS-1:0]  lim;
        logic [REG_BITS-1:0]  offset;
        int                   pick;
        for (int n = 0; n < count; n++) begin
            pick  = $urandom_range(99);
            base  = beat_known ? beat_time : start_time;
            lim   = beat_known ? stale_limit : grace_limit;
            noise = TIME_BITS'({$urandom, $urandom});
            if (pick < 35) begin
                // fresh heartbeat, now and then a big jump forward
                if ($urandom_range(9) == 0)
                    send_item(OP_FEED, base + TIME_BITS'({4'($urandom_range(15)), $urandom}));
                else
                    send_item(OP_FEED, base + TIME_BITS'($urandom_range(1, 65535)));
            end else if (pick < 45) begin
                // stale heartbeat, equal or older than the stored one
                send_item(OP_FEED, (base == '1) ? noise : noise % (base + 1'b1));
            end else if (pick < 88) begin
                // check within the limit, often right on it
                case ($urandom_range(3))
                    0:       offset = lim;
                    1:       offset = $urandom_range((lim < 16) ? lim : 16);
                    default: offset = $urandom_range(lim);
                endcase
                send_item(OP_CHECK, base + TIME_BITS'(offset));
            end else begin
                // check with the clock behind the reference point
                back = TIME_BITS'($urandom_range(1, 1 << 20));
                send_item(OP_CHECK, (back > base) ? '0 : base - back);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // Before any heartbeat: first check opens the grace window, earlier
    // clocks and ages right on the window stay healthy, for default and
    // extreme window settings.
    task automatic test_startup_grace();
        send_item(OP_CHECK, 48'h10_0000);
        send_item(OP_CHECK, 48'h0F_FFFF);
        send_item(OP_CHECK, 48'h10_0000 + GRACE_WINDOW_RESET);
        drain_items();
        cfg_write(REG_GRACE_WINDOW, '1);
        send_item(OP_CHECK, 48'h10_0000 + 48'hFFFF_FFFF);
        drain_items();
        cfg_write(REG_GRACE_WINDOW, '0);
        send_item(OP_CHECK, 48'h10_0000);
    endtask

    // Heartbeat rules: first feed lands even at time zero, equal and older
    // feeds are dropped, age on the limit and negative ages stay healthy.
    task automatic test_feed_rules();
        send_item(OP_FEED, '0);
        send_item(OP_CHECK, TIME_BITS'(STALE_TIMEOUT_RESET));
        send_item(OP_FEED, 48'd5000);
        send_item(OP_FEED, 48'd3000);
        send_item(OP_FEED, 48'd5000);
        // trips only if the older feed was wrongly stored
        send_item(OP_CHECK, 48'd5000 + STALE_TIMEOUT_RESET);
        send_item(OP_CHECK, 48'd4999);
    endtask

    // Random traffic under one idling mix and one stale timeout.
    task automatic test_traffic_phase(input int send_pct, input int recv_pct,
                                      input logic [REG_BITS-1:0] timeout, input int count);
        drain_items();
        cfg_write(REG_STALE_TIMEOUT, timeout);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        run_traffic(count);
    endtask

    // Hold the output off for a long stretch while the sender keeps pushing,
    // so the pipeline fills and the input stalls.
    task automatic test_backpressure();
        drain_items();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 60;
        run_traffic(40);
    endtask

    // Trip the latch on an age one tick past a zero timeout, then confirm
    // the latch holds through later feeds, the top stamp and random noise.
    task automatic test_trip_latch();
        logic [TIME_BITS-1:0] t;
        drain_items();
        cfg_write(REG_STALE_TIMEOUT, '0);
        t = beat_time + TIME_BITS'($urandom_range(1, 4096));
        send_item(OP_FEED, t);
        send_item(OP_CHECK, t);
        send_item(OP_CHECK, t + 1'b1);
        send_item(OP_CHECK, t);
        send_item(OP_FEED, '1);
        send_item(OP_CHECK, '1);
        send_item(OP_CHECK, '0);
        for (int n = 0; n < 30; n++) begin
            send_item(hbw_op_t'($urandom_range(1)), TIME_BITS'({$urandom, $urandom}));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        // every input known from time zero, reset held low before release
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed items run under the first idling mix
        send_idle_pct = 38;
        recv_idle_pct = 68;
        test_startup_grace();
        test_feed_rules();

        test_traffic_phase(38, 68, $urandom_range(1000, 1 << 24), 140);
        test_traffic_phase(68, 38, '1, 140);
        test_backpressure();
        test_traffic_phase(0, 0, 32'd7, 80);
        test_trip_latch();

        // let the last items clear, then conclude
        drain_items();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
